// ===== src/sfl_pkg.sv =====
`default_nettype none

package sfl_pkg;

  localparam int unsigned FLASH_AW   = 24;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_STOP  = 8'hF7;
  localparam logic [1:0] HDR_DONE    = 2'd3;

  typedef enum logic [1:0] {
    OP_ERASE    = 2'd0,
    OP_WRITE    = 2'd1,
    OP_FINALISE = 2'd2,
    OP_RESET    = 2'd3
  } flash_op_t;

  typedef enum logic [1:0] {
    REG_MFR  = 2'd0,
    REG_DEV  = 2'd1,
    REG_PAGE = 2'd2,
    REG_BOOT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [6:0]          mfr;
    logic [6:0]          dev;
    logic [4:0]          page_log2;
    logic [FLASH_AW-1:0] boot_start;
  } cfg_t;

  // ops bit n requests flash_op n; results go out lowest bit first
  typedef struct packed {
    logic [3:0]          ops;
    logic [FLASH_AW-1:0] addr;
    logic [WORD_W-1:0]   word;
  } job_t;

endpackage

`default_nettype wire

// ===== src/sfl_front.sv =====
`default_nettype none

module sfl_front #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_rx_byte,
  input  wire logic              q_full,
  input  wire sfl_pkg::cfg_t     cfg,
  output logic                   push,
  output sfl_pkg::job_t          job
);

  localparam int unsigned AW = ADDRESS_BITS;
  localparam int unsigned CW = (AW > sfl_pkg::FLASH_AW) ? AW : sfl_pkg::FLASH_AW;

  logic [1:0]    hdr_r, hdr_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          hi_r, hi_nxt;
  logic [7:0]    low_r, low_nxt;
  logic [AW-1:0] wa_r, wa_nxt;

  logic [7:0]    expect_byte;
  logic [AW-1:0] pmask;
  logic [AW-1:0] wa_inc;
  logic [7:0]    merged;
  logic          on_page;
  logic          below_boot;

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      pmask[i] = (i < int'(cfg.page_log2));
    end
  end

  always_comb begin
    hdr_nxt   = hdr_r;
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    low_nxt   = low_r;
    wa_nxt    = wa_r;
    push      = 1'b0;
    job       = '0;

    unique case (hdr_r)
      2'd0:    expect_byte = sfl_pkg::SYSEX_START;
      2'd1:    expect_byte = {1'b0, cfg.mfr};
      default: expect_byte = {1'b0, cfg.dev};
    endcase

    wa_inc     = wa_r + AW'(2);
    merged     = {hi_r | in_rx_byte[7], in_rx_byte[6:0]};
    on_page    = ((wa_r & pmask) == '0);
    below_boot = (CW'(wa_r) < CW'(cfg.boot_start));
    job.addr   = sfl_pkg::FLASH_AW'(wa_r);

    if (in_valid && !q_full) begin
      if (hdr_r != sfl_pkg::HDR_DONE) begin
        if (in_rx_byte != expect_byte) begin
          hdr_nxt   = '0;
          phase_nxt = '0;
          hi_nxt    = 1'b0;
          low_nxt   = '0;
          wa_nxt    = '0;
          push      = 1'b1;
          job.ops[sfl_pkg::OP_RESET] = 1'b1;
        end else begin
          hdr_nxt = hdr_r + 2'd1;
        end
      end else if (in_rx_byte == sfl_pkg::SYSEX_STOP) begin
        hdr_nxt   = '0;
        phase_nxt = '0;
        hi_nxt    = 1'b0;
        low_nxt   = '0;
        wa_nxt    = '0;
        push      = 1'b1;
        job.ops[sfl_pkg::OP_FINALISE] = !on_page;
        job.ops[sfl_pkg::OP_RESET]    = 1'b1;
      end else begin
        phase_nxt = phase_r + 2'd1;
        if (!phase_r[0]) begin
          hi_nxt = (in_rx_byte != 8'd0);
        end else begin
          hi_nxt = 1'b0;
          if (!phase_r[1]) begin
            low_nxt = merged;
          end else if (below_boot) begin
            push     = 1'b1;
            wa_nxt   = wa_inc;
            job.word = {merged, low_r};
            job.ops[sfl_pkg::OP_ERASE]    = on_page;
            job.ops[sfl_pkg::OP_WRITE]    = 1'b1;
            job.ops[sfl_pkg::OP_FINALISE] = ((wa_inc & pmask) == '0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= '0;
      phase_r <= '0;
      hi_r    <= 1'b0;
      low_r   <= '0;
      wa_r    <= '0;
    end else begin
      hdr_r   <= hdr_nxt;
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      low_r   <= low_nxt;
      wa_r    <= wa_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/sfl_fifo.sv =====
`default_nettype none

module sfl_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sfl_pkg::job_t wr_job,
  input  wire logic          pop,
  output sfl_pkg::job_t      rd_job,
  output logic               full,
  output logic               empty
);

  sfl_pkg::job_t mem_r [sfl_pkg::QDEPTH];

  logic [sfl_pkg::QPTR_W-1:0] wp_r, wp_nxt;
  logic [sfl_pkg::QPTR_W-1:0] rp_r, rp_nxt;
  logic [sfl_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == sfl_pkg::QCNT_W'(sfl_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + sfl_pkg::QCNT_W'(push) - sfl_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

// ===== src/sfl_back.sv =====
`default_nettype none

module sfl_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sfl_pkg::job_t                head,
  input  wire logic                         q_empty,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_flash_op,
  output logic [sfl_pkg::FLASH_AW-1:0]      out_flash_address,
  output logic [sfl_pkg::WORD_W-1:0]        out_write_word,
  output logic                              out_last
);

  logic [3:0] sent_r, sent_nxt;
  logic       valid_r, valid_nxt;

  sfl_pkg::flash_op_t               op_r;
  logic [sfl_pkg::FLASH_AW-1:0]     addr_r;
  logic [sfl_pkg::WORD_W-1:0]       word_r;
  logic                             last_r;

  logic [3:0]         rem;
  logic [3:0]         pick;
  logic [3:0]         rest;
  logic               adv;
  logic               load;
  sfl_pkg::flash_op_t pick_op;

  always_comb begin
    rem  = head.ops & ~sent_r;
    pick = rem & (~rem + 4'd1);
    rest = rem & ~pick;
    adv  = !valid_r || !out_stall;
    load = adv && !q_empty;
    pop  = load && (rest == 4'd0);

    unique case (pick)
      4'b0001: pick_op = sfl_pkg::OP_ERASE;
      4'b0010: pick_op = sfl_pkg::OP_WRITE;
      4'b0100: pick_op = sfl_pkg::OP_FINALISE;
      default: pick_op = sfl_pkg::OP_RESET;
    endcase

    sent_nxt  = sent_r;
    valid_nxt = valid_r;
    if (load) begin
      sent_nxt  = pop ? 4'd0 : (sent_r | pick);
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      sent_r  <= sent_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r   <= pick_op;
      addr_r <= (pick_op == sfl_pkg::OP_RESET) ? '0 : head.addr;
      word_r <= (pick_op == sfl_pkg::OP_WRITE) ? head.word : '0;
      last_r <= (rest == 4'd0);
    end
  end

  assign out_valid         = valid_r;
  assign out_flash_op      = op_r;
  assign out_flash_address = addr_r;
  assign out_write_word    = word_r;
  assign out_last          = last_r;

endmodule

`default_nettype wire

// ===== src/sysex_firmware_flash_loader.sv =====
// The first result of a byte passes through the command queue and then the output register.
// Throughput: one byte per cycle while the two-entry command queue has room;
// the result port sends one command per cycle while out_stall is low, and a byte yields up to three commands.
// A byte that yields no command never enters the queue.
// Reset (rst_n low, synchronous): parser, queue and output valid clear;
// config registers return to their defaults.
`default_nettype none

module sysex_firmware_flash_loader #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_flash_op,
  output logic [sfl_pkg::FLASH_AW-1:0]          out_flash_address,
  output logic [sfl_pkg::WORD_W-1:0]            out_write_word,
  output logic                                  out_last,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sfl_pkg::APB_AW-1:0]       paddr,
  input  wire logic [sfl_pkg::APB_DW-1:0]       pwdata,
  output logic [sfl_pkg::APB_DW-1:0]            prdata,
  output logic                                  pready
);

  sfl_pkg::cfg_t cfg_r;
  sfl_pkg::job_t push_job;
  sfl_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic          cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mfr        <= 7'd125;
      cfg_r.dev        <= 7'd0;
      cfg_r.page_log2  <= 5'd7;
      cfg_r.boot_start <= sfl_pkg::FLASH_AW'(61440);
    end else if (cfg_wr) begin
      unique case (sfl_pkg::cfg_reg_t'(paddr[3:2]))
        sfl_pkg::REG_MFR:  cfg_r.mfr        <= pwdata[6:0];
        sfl_pkg::REG_DEV:  cfg_r.dev        <= pwdata[6:0];
        sfl_pkg::REG_PAGE: cfg_r.page_log2  <= pwdata[4:0];
        sfl_pkg::REG_BOOT: cfg_r.boot_start <= pwdata[sfl_pkg::FLASH_AW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sfl_pkg::cfg_reg_t'(paddr[3:2]))
      sfl_pkg::REG_MFR:  prdata = sfl_pkg::APB_DW'(cfg_r.mfr);
      sfl_pkg::REG_DEV:  prdata = sfl_pkg::APB_DW'(cfg_r.dev);
      sfl_pkg::REG_PAGE: prdata = sfl_pkg::APB_DW'(cfg_r.page_log2);
      sfl_pkg::REG_BOOT: prdata = sfl_pkg::APB_DW'(cfg_r.boot_start);
    endcase
  end

  sfl_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .cfg        (cfg_r),
    .push       (push),
    .job        (push_job)
  );

  sfl_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  sfl_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head_job),
    .q_empty           (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_flash_op      (out_flash_op),
    .out_flash_address (out_flash_address),
    .out_write_word    (out_write_word),
    .out_last          (out_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("command queue underflow");

  a_reset_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_flash_op == sfl_pkg::OP_RESET) |->
      out_last && (out_flash_address == '0) && (out_write_word == '0))
    else $error("reset request malformed");

  a_word_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_flash_op != sfl_pkg::OP_WRITE) |-> (out_write_word == '0))
    else $error("data on non-write command");

endmodule

`default_nettype wire

// ===== bench/sfl_checker.sv =====
module sfl_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [7:0]                in_rx_byte,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [1:0]                out_flash_op,
  input  logic [sfl_pkg::FLASH_AW-1:0] out_flash_address,
  input  logic [sfl_pkg::WORD_W-1:0]   out_write_word,
  input  logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfl_pkg::APB_AW-1:0]   paddr,
  input  logic [sfl_pkg::APB_DW-1:0]   pwdata,
  input  logic                      pready,
  output int unsigned               n_fail,
  output int unsigned               n_waiting,
  output int unsigned               n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  HIGH_BIT    = 8'h80;

  typedef struct packed {
    sfl_pkg::flash_op_t           op;
    logic [sfl_pkg::FLASH_AW-1:0] addr;
    logic [sfl_pkg::WORD_W-1:0]   word;
    logic                         last;
  } flash_cmd_t;

  flash_cmd_t flash_cmd_q [$];

  logic [6:0]                   cfg_mfr;
  logic [6:0]                   cfg_dev;
  logic [4:0]                   cfg_page;
  logic [sfl_pkg::FLASH_AW-1:0] cfg_boot;

  logic [1:0]                   hdr_pos;
  logic [1:0]                   pair_ph;
  logic [7:0]                   hi_bit;
  logic [7:0]                   lo_byte;
  logic [sfl_pkg::FLASH_AW-1:0] wr_addr;

  function automatic flash_cmd_t flash_cmd(sfl_pkg::flash_op_t op,
                                           logic [sfl_pkg::FLASH_AW-1:0] a,
                                           logic [sfl_pkg::WORD_W-1:0] w);
    flash_cmd_t c;
    c.op   = op;
    c.addr = a;
    c.word = w;
    c.last = 1'b0;
    return c;
  endfunction

  function automatic logic [sfl_pkg::FLASH_AW-1:0] page_mask();
    logic [63:0] m;
    m = (64'd1 << cfg_page) - 64'd1;
    return m[sfl_pkg::FLASH_AW-1:0];
  endfunction

  task automatic clear_parser();
    hdr_pos = 2'd0;
    pair_ph = 2'd0;
    hi_bit  = 8'h00;
    lo_byte = 8'h00;
    wr_addr = '0;
  endtask

  task automatic predict_flash_cmds(logic [7:0] b);
    flash_cmd_t                   res [0:2];
    int                           n;
    logic [7:0]                   want;
    logic [7:0]                   merged;
    logic [sfl_pkg::FLASH_AW-1:0] pm;
    n  = 0;
    pm = page_mask();
    if (hdr_pos != sfl_pkg::HDR_DONE) begin
      want = (hdr_pos == 2'd0) ? sfl_pkg::SYSEX_START :
             (hdr_pos == 2'd1) ? {1'b0, cfg_mfr} : {1'b0, cfg_dev};
      if (b != want) begin
        clear_parser();
        res[n] = flash_cmd(sfl_pkg::OP_RESET, '0, '0);
        n++;
      end else begin
        hdr_pos = hdr_pos + 2'd1;
      end
    end else if (b == sfl_pkg::SYSEX_STOP) begin
      if ((wr_addr & pm) != '0) begin
        res[n] = flash_cmd(sfl_pkg::OP_FINALISE, wr_addr, '0);
        n++;
      end
      res[n] = flash_cmd(sfl_pkg::OP_RESET, '0, '0);
      n++;
      clear_parser();
    end else begin
      if (!pair_ph[0]) begin
        hi_bit = (b != 8'h00) ? HIGH_BIT : 8'h00;
      end else begin
        merged = hi_bit | b;
        hi_bit = 8'h00;
        if (!pair_ph[1]) begin
          lo_byte = merged;
        end else if (wr_addr < cfg_boot) begin
          if ((wr_addr & pm) == '0) begin
            res[n] = flash_cmd(sfl_pkg::OP_ERASE, wr_addr, '0);
            n++;
          end
          res[n] = flash_cmd(sfl_pkg::OP_WRITE, wr_addr, {merged, lo_byte});
          n++;
          wr_addr = wr_addr + sfl_pkg::FLASH_AW'(2);
          if ((wr_addr & pm) == '0) begin
            res[n] = flash_cmd(sfl_pkg::OP_FINALISE, wr_addr - sfl_pkg::FLASH_AW'(2), '0);
            n++;
          end
        end
      end
      pair_ph = pair_ph + 2'd1;
    end
    if (n > 0) begin
      res[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      flash_cmd_q.push_back(res[i]);
    end
  endtask

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    n_fail++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    flash_cmd_t exp_cmd;
    if (!rst_n) begin
      flash_cmd_q.delete();
      cfg_mfr  = 7'd125;
      cfg_dev  = 7'd0;
      cfg_page = 5'd7;
      cfg_boot = 24'd61440;
      clear_parser();
    end else begin
      if (out_valid && !out_stall) begin
        if (flash_cmd_q.size() == 0) begin
          n_fail++;
          $display("%0t ns: unexpected result, expected none, got op %0d addr %0h word %0h",
                   $time, out_flash_op, out_flash_address, out_write_word);
        end else begin
          exp_cmd = flash_cmd_q.pop_front();
          n_checked++;
          if (out_flash_op !== exp_cmd.op)
            report_field("flash_op", 32'(exp_cmd.op), 32'(out_flash_op));
          if (out_flash_address !== exp_cmd.addr)
            report_field("flash_address", 32'(exp_cmd.addr), 32'(out_flash_address));
          if (out_write_word !== exp_cmd.word)
            report_field("write_word", 32'(exp_cmd.word), 32'(out_write_word));
          if (out_last !== exp_cmd.last)
            report_field("last", 32'(exp_cmd.last), 32'(out_last));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (sfl_pkg::cfg_reg_t'(paddr[sfl_pkg::APB_AW-1:2]))
          sfl_pkg::REG_MFR:  cfg_mfr  = pwdata[6:0];
          sfl_pkg::REG_DEV:  cfg_dev  = pwdata[6:0];
          sfl_pkg::REG_PAGE: cfg_page = pwdata[4:0];
          sfl_pkg::REG_BOOT: cfg_boot = pwdata[sfl_pkg::FLASH_AW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_flash_cmds(in_rx_byte);
      end
    end
    n_waiting = flash_cmd_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS  = 320;
  localparam int unsigned PHASES = 5;
  localparam int unsigned LIMIT  = 200000;
  localparam int unsigned HOLD   = 80;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_rx_byte = 8'h00;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   out_flash_op;
  logic [sfl_pkg::FLASH_AW-1:0] out_flash_address;
  logic [sfl_pkg::WORD_W-1:0]   out_write_word;
  logic                         out_last;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [sfl_pkg::APB_AW-1:0]   paddr = '0;
  logic [sfl_pkg::APB_DW-1:0]   pwdata = '0;
  logic [sfl_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  int unsigned n_fail;
  int unsigned n_waiting;
  int unsigned n_checked;
  int unsigned n_sent = 0;
  int unsigned n_settings = 0;
  int unsigned cycle_count = 0;

  bit         tx_idle_on = 1'b0;
  bit         rx_idle_on = 1'b0;
  bit         hold_req = 1'b0;
  logic [6:0] cur_mfr = 7'd125;
  logic [6:0] cur_dev = 7'd0;

  sysex_firmware_flash_loader dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_flash_op      (out_flash_op),
    .out_flash_address (out_flash_address),
    .out_write_word    (out_write_word),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  sfl_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_flash_op      (out_flash_op),
    .out_flash_address (out_flash_address),
    .out_write_word    (out_write_word),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .n_fail            (n_fail),
    .n_waiting         (n_waiting),
    .n_checked         (n_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timed out after %0d cycles", LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // one byte request, held until taken
  task automatic send_byte(logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic write_reg(sfl_pkg::cfg_reg_t r, logic [sfl_pkg::APB_DW-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (r)
      sfl_pkg::REG_MFR: cur_mfr = v[6:0];
      sfl_pkg::REG_DEV: cur_dev = v[6:0];
      default: ;
    endcase
  endtask

  // drain: byte with no command may still be in flight after the last result
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (n_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(logic [sfl_pkg::APB_DW-1:0] mfr, logic [sfl_pkg::APB_DW-1:0] dev,
                           logic [sfl_pkg::APB_DW-1:0] page,
                           logic [sfl_pkg::APB_DW-1:0] boot);
    settle();
    write_reg(sfl_pkg::REG_MFR, mfr);
    write_reg(sfl_pkg::REG_DEV, dev);
    write_reg(sfl_pkg::REG_PAGE, page);
    write_reg(sfl_pkg::REG_BOOT, boot);
    n_settings++;
  endtask

  task automatic send_packet(int n_data, bit corrupt, bit close);
    logic [7:0] hdr [0:2];
    logic [7:0] b;
    int         k;
    hdr[0] = sfl_pkg::SYSEX_START;
    hdr[1] = {1'b0, cur_mfr};
    hdr[2] = {1'b0, cur_dev};
    if (corrupt) begin
      k = $urandom_range(0, 2);
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < 3; i++) begin
      send_byte(hdr[i]);
    end
    for (int i = 0; i < n_data; i++) begin
      if ((i % 2) == 0 && $urandom_range(0, 2) == 0) begin
        b = 8'h00;
      end else begin
        b = 8'($urandom_range(0, 255));
        while (b == sfl_pkg::SYSEX_STOP) b = 8'($urandom_range(0, 255));
      end
      send_byte(b);
    end
    if (close) begin
      send_byte(sfl_pkg::SYSEX_STOP);
    end
  endtask

  task automatic random_phase(int unsigned budget);
    int unsigned stop_at;
    int unsigned kind;
    int          len;
    stop_at = n_sent + budget;
    while (n_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind == 1) begin
        send_packet($urandom_range(0, 8), 1'b1, 1'b1);
      end else begin
        len = int'(4 * $urandom_range(0, 10) + $urandom_range(0, 3));
        if (len > int'(stop_at - n_sent)) len = int'(stop_at - n_sent);
        send_packet(len, 1'b0, $urandom_range(0, 7) != 0);
      end
    end
  endtask

  initial begin
    logic [7:0]  probe [$];
    int unsigned budget;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    n_settings = 1;

    // defaults: header mismatch at each position, wide second byte, partial-page stop
    probe = '{sfl_pkg::SYSEX_STOP, sfl_pkg::SYSEX_START, 8'h7C, sfl_pkg::SYSEX_START,
              8'h7D, 8'h01, sfl_pkg::SYSEX_START, 8'h7D, 8'h00, 8'hFF, 8'hFF, 8'h00,
              8'h00, 8'h01, 8'h7F, 8'h00, 8'h80, sfl_pkg::SYSEX_STOP};
    foreach (probe[i]) send_byte(probe[i]);

    // two-byte pages: erase/write/finalise per word, stop on a page boundary
    configure(32'hFFFF_FF80, 32'd127, 32'd1, 32'h00FF_FFFF);
    probe = '{sfl_pkg::SYSEX_START, 8'h00, 8'h7F, 8'h80, 8'h00, 8'h7F, 8'h7F,
              sfl_pkg::SYSEX_STOP};
    foreach (probe[i]) send_byte(probe[i]);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 1'b1;
    send_packet(40, 1'b0, 1'b1);
    budget = (ITEMS - n_sent) / PHASES;
    random_phase(budget);

    configure(32'd127, 32'd0, 32'd0, $urandom_range(0, 60));
    random_phase(budget);

    configure($urandom_range(0, 127), $urandom_range(0, 127), 32'd31, 32'd0);
    random_phase(budget);

    configure($urandom_range(0, 127), $urandom_range(0, 127), 32'd16, 32'h00FF_FFFF);
    random_phase(budget);

    configure($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(2, 5),
              $urandom_range(0, 512));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(budget);

    settle();
    repeat (10) @(negedge clk);
    $display("Sent %0d bytes under %0d register settings; %0d flash commands compared.",
             n_sent, n_settings, n_checked);
    $display("Exercised header mismatches, stop bytes, protected region and a long output hold.");
    if (n_fail == 0 && n_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sfl_pkg.sv
src/sfl_front.sv
src/sfl_fifo.sv
src/sfl_back.sv
src/sysex_firmware_flash_loader.sv
bench/sfl_checker.sv
bench/tb_top.sv
